FILE: rtl/chacha20_stream_cipher_assert.svh
// Assertion macros for the port-level checker file
`ifndef CHACHA20_STREAM_CIPHER_ASSERT_SVH
`define CHACHA20_STREAM_CIPHER_ASSERT_SVH

// same-cycle implication
`define CC20_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CC20_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/cc20_pkg.sv
// Types, constants and quarter-round function for the ChaCha20 stream cipher
`default_nettype none
package cc20_pkg;

  localparam int DOUBLE_ROUNDS = 10;
  localparam int RND_W         = $clog2(DOUBLE_ROUNDS + 1);
  localparam int WORDS         = 8;
  localparam int POS_W         = $clog2(WORDS);

  typedef logic [31:0] word_t;
  typedef logic [63:0] dword_t;
  typedef logic [15:0][31:0] state_t;
  typedef logic [3:0][31:0] quad_t;

  localparam word_t SIGMA0 = 32'h61707865;
  localparam word_t SIGMA1 = 32'h3320646e;
  localparam word_t SIGMA2 = 32'h79622d32;
  localparam word_t SIGMA3 = 32'h6b206574;

  typedef enum logic [2:0] {
    REG_KEY0      = 3'd0,
    REG_KEY1      = 3'd1,
    REG_KEY2      = 3'd2,
    REG_KEY3      = 3'd3,
    REG_NONCE_LO  = 3'd4,
    REG_NONCE_HI  = 3'd5,
    REG_INIT_CTR  = 3'd6
  } reg_idx_t;

  function automatic word_t rotl(input word_t v, input int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  // in/out order: a, b, c, d
  function automatic quad_t qround(input quad_t q);
    word_t a, b, c, d;
    a = q[0]; b = q[1]; c = q[2]; d = q[3];
    a = a + b; d = rotl(d ^ a, 16);
    c = c + d; b = rotl(b ^ c, 12);
    a = a + b; d = rotl(d ^ a, 8);
    c = c + d; b = rotl(b ^ c, 7);
    qround = {d, c, b, a};
  endfunction

endpackage
`default_nettype wire

FILE: rtl/cc20_dround.sv
// One ChaCha20 double round: column then diagonal quarter rounds
`default_nettype none
module cc20_dround (
  input  var cc20_pkg::state_t din,
  output var cc20_pkg::state_t dout
);

  cc20_pkg::state_t col;
  cc20_pkg::quad_t  c0, c1, c2, c3, d0, d1, d2, d3;

  always_comb begin
    c0 = cc20_pkg::qround({din[12], din[8],  din[4], din[0]});
    c1 = cc20_pkg::qround({din[13], din[9],  din[5], din[1]});
    c2 = cc20_pkg::qround({din[14], din[10], din[6], din[2]});
    c3 = cc20_pkg::qround({din[15], din[11], din[7], din[3]});
    col[0] = c0[0]; col[4] = c0[1]; col[8]  = c0[2]; col[12] = c0[3];
    col[1] = c1[0]; col[5] = c1[1]; col[9]  = c1[2]; col[13] = c1[3];
    col[2] = c2[0]; col[6] = c2[1]; col[10] = c2[2]; col[14] = c2[3];
    col[3] = c3[0]; col[7] = c3[1]; col[11] = c3[2]; col[15] = c3[3];
    d0 = cc20_pkg::qround({col[15], col[10], col[5], col[0]});
    d1 = cc20_pkg::qround({col[12], col[11], col[6], col[1]});
    d2 = cc20_pkg::qround({col[13], col[8],  col[7], col[2]});
    d3 = cc20_pkg::qround({col[14], col[9],  col[4], col[3]});
    dout[0] = d0[0]; dout[5] = d0[1]; dout[10] = d0[2]; dout[15] = d0[3];
    dout[1] = d1[0]; dout[6] = d1[1]; dout[11] = d1[2]; dout[12] = d1[3];
    dout[2] = d2[0]; dout[7] = d2[1]; dout[8]  = d2[2]; dout[13] = d2[3];
    dout[3] = d3[0]; dout[4] = d3[1]; dout[9]  = d3[2]; dout[14] = d3[3];
  end

endmodule
`default_nettype wire

FILE: rtl/cc20_cell.sv
// Keystream cell: holds one 64-bit word, parallel load or shift from neighbour
`default_nettype none
module cc20_cell (
  input  var logic             clk,
  input  var logic             load,
  input  var logic             shift,
  input  var cc20_pkg::dword_t load_data,
  input  var cc20_pkg::dword_t shift_in,
  output var cc20_pkg::dword_t data
);

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end else if (shift) begin
      data <= shift_in;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/chacha20_stream_cipher.sv
// ChaCha20 stream cipher top level: config, block generator, keystream cell chain
//
//   channel  dir  handshake              payload
//   in       in   in_valid / in_ready    text_word[63:0], message_start
//   out      out  out_valid / out_ready  cipher_word[63:0], block_number[31:0]
//   cfg      in   write_enable           write_index[2:0], write_data[63:0]
//
// A new block is made in steps: load, one double round per cycle, then the final
// add into the cell chain; no new input beat is taken while a block is made.
// One input beat is held; it is freed only once the output register is empty or read.
// rst is synchronous; after it the first block uses counter zero.
`default_nettype none
module chacha20_stream_cipher (
  input  var logic        clk,
  input  var logic        rst,
  input  var logic        in_valid,
  output var logic        in_ready,
  input  var logic [63:0] text_word,
  input  var logic        message_start,
  output var logic        out_valid,
  input  var logic        out_ready,
  output var logic [63:0] cipher_word,
  output var logic [31:0] block_number,
  input  var logic        write_enable,
  input  var logic [2:0]  write_index,
  input  var logic [63:0] write_data
);

  cc20_pkg::dword_t key0, key1, key2, key3, nonce_lo;
  cc20_pkg::word_t  nonce_hi, init_ctr, counter;

  logic                        hold_valid, buffer_ready, busy;
  logic [cc20_pkg::POS_W-1:0]  pos;
  logic [cc20_pkg::RND_W-1:0]  rnd;
  cc20_pkg::dword_t            hold_text;
  cc20_pkg::state_t            work, init, work_next, fresh;
  cc20_pkg::dword_t [cc20_pkg::WORDS-1:0] cell_q, ks;
  logic in_fire, consume, gen_go, rnd_done;

  assign consume  = hold_valid && buffer_ready && (!out_valid || out_ready);
  assign in_ready = !hold_valid || consume;
  assign in_fire  = in_valid && in_ready;
  assign gen_go   = hold_valid && !buffer_ready && !busy;
  assign rnd_done = busy && (rnd == cc20_pkg::RND_W'(cc20_pkg::DOUBLE_ROUNDS));

  always_comb begin
    fresh = {nonce_hi, nonce_lo[63:32], nonce_lo[31:0], counter,
             key3[63:32], key3[31:0], key2[63:32], key2[31:0],
             key1[63:32], key1[31:0], key0[63:32], key0[31:0],
             cc20_pkg::SIGMA3, cc20_pkg::SIGMA2, cc20_pkg::SIGMA1, cc20_pkg::SIGMA0};
    for (int i = 0; i < cc20_pkg::WORDS; i++) begin
      ks[i] = {work[2*i+1] + init[2*i+1], work[2*i] + init[2*i]};
    end
  end

  cc20_dround u_dround (.din(work), .dout(work_next));

  genvar g;
  generate
    for (g = 0; g < cc20_pkg::WORDS; g++) begin : g_cell
      if (g == cc20_pkg::WORDS - 1) begin : g_last
        cc20_cell u_cell (
          .clk(clk), .load(rnd_done), .shift(consume), .load_data(ks[g]),
          .shift_in('0), .data(cell_q[g])
        );
      end else begin : g_mid
        cc20_cell u_cell (
          .clk(clk), .load(rnd_done), .shift(consume), .load_data(ks[g]),
          .shift_in(cell_q[g+1]), .data(cell_q[g])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      key0     <= '0;
      key1     <= '0;
      key2     <= '0;
      key3     <= '0;
      nonce_lo <= '0;
      nonce_hi <= '0;
      init_ctr <= 32'd1;
    end else if (write_enable) begin
      unique case (write_index)
        cc20_pkg::REG_KEY0:     key0     <= write_data;
        cc20_pkg::REG_KEY1:     key1     <= write_data;
        cc20_pkg::REG_KEY2:     key2     <= write_data;
        cc20_pkg::REG_KEY3:     key3     <= write_data;
        cc20_pkg::REG_NONCE_LO: nonce_lo <= write_data;
        cc20_pkg::REG_NONCE_HI: nonce_hi <= write_data[31:0];
        cc20_pkg::REG_INIT_CTR: init_ctr <= write_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid   <= 1'b0;
      buffer_ready <= 1'b0;
      busy         <= 1'b0;
      pos          <= '0;
      counter      <= '0;
      rnd          <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (in_fire) begin
        hold_valid <= 1'b1;
      end else if (consume) begin
        hold_valid <= 1'b0;
      end
      if (consume) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (gen_go) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (rnd_done) begin
        busy <= 1'b0;
      end else if (busy) begin
        rnd <= rnd + 1'b1;
      end
      // new message overrides any word retired this cycle
      if (in_fire && message_start) begin
        counter      <= init_ctr;
        pos          <= '0;
        buffer_ready <= 1'b0;
      end else if (consume) begin
        pos <= pos + 1'b1;
        if (pos == cc20_pkg::POS_W'(cc20_pkg::WORDS - 1)) begin
          counter      <= counter + 1'b1;
          buffer_ready <= 1'b0;
        end
      end else if (rnd_done) begin
        buffer_ready <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_text <= text_word;
    end
    if (consume) begin
      cipher_word  <= hold_text ^ cell_q[0];
      block_number <= counter;
    end
    if (gen_go) begin
      work <= fresh;
      init <= fresh;
    end else if (busy && !rnd_done) begin
      work <= work_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/cc20_checker.sv
// Port-level checker for the ChaCha20 stream cipher, bound to the top level
`default_nettype none
`include "chacha20_stream_cipher_assert.svh"
module cc20_checker (
  input var logic        clk,
  input var logic        rst,
  input var logic        in_ready,
  input var logic        out_valid,
  input var logic        out_ready,
  input var logic [63:0] cipher_word,
  input var logic [31:0] block_number
);

  `CC20_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(cipher_word) && $stable(block_number))
  `CC20_ASSERT_NOW(a_rst_out, $past(rst), !out_valid)
  `CC20_ASSERT_NOW(a_rst_ready, $past(rst), in_ready)

endmodule

bind chacha20_stream_cipher cc20_checker u_cc20_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .cipher_word(cipher_word), .block_number(block_number)
);
`default_nettype wire

FILE: tb/sv/chacha20_stream_cipher_test.sv
// Testbench for the ChaCha20 stream cipher: predictor, checker, directed and random tests
`timescale 1ns / 100ps
`default_nettype none
module chacha20_stream_cipher_test;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] text_word = '0;
  logic        message_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] cipher_word;
  logic [31:0] block_number;
  logic        write_enable = 1'b0;
  logic [2:0]  write_index = '0;
  logic [63:0] write_data = '0;

  chacha20_stream_cipher u_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct packed {
    logic [63:0] cipher;
    logic [31:0] blk;
  } cipher_beat_t;

  // predictor state
  logic [63:0] key_q [4];
  logic [63:0] nonce_lo_q;
  logic [31:0] nonce_hi_q;
  logic [31:0] init_ctr_q;
  logic [63:0] keystream_q [8];
  logic [31:0] ctr_q;
  logic [2:0]  pos_q;
  logic        have_block;

  cipher_beat_t expected_beats [$];
  int  fail_count = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_recv = 1'b0;
  int  idle_cycles = 0;

  function automatic logic [31:0] rol32(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void mix(ref logic [31:0] s [16], input int a, int b, int c, int d);
    s[a] += s[b]; s[d] = rol32(s[d] ^ s[a], 16);
    s[c] += s[d]; s[b] = rol32(s[b] ^ s[c], 12);
    s[a] += s[b]; s[d] = rol32(s[d] ^ s[a], 8);
    s[c] += s[d]; s[b] = rol32(s[b] ^ s[c], 7);
  endfunction

  task automatic fill_keystream();
    logic [31:0] init [16];
    logic [31:0] w [16];
    init[0] = cc20_pkg::SIGMA0; init[1] = cc20_pkg::SIGMA1;
    init[2] = cc20_pkg::SIGMA2; init[3] = cc20_pkg::SIGMA3;
    for (int i = 0; i < 4; i++) begin
      init[4 + 2*i] = key_q[i][31:0];
      init[5 + 2*i] = key_q[i][63:32];
    end
    init[12] = ctr_q;
    init[13] = nonce_lo_q[31:0];
    init[14] = nonce_lo_q[63:32];
    init[15] = nonce_hi_q;
    w = init;
    for (int r = 0; r < cc20_pkg::DOUBLE_ROUNDS; r++) begin
      mix(w, 0, 4, 8, 12); mix(w, 1, 5, 9, 13);
      mix(w, 2, 6, 10, 14); mix(w, 3, 7, 11, 15);
      mix(w, 0, 5, 10, 15); mix(w, 1, 6, 11, 12);
      mix(w, 2, 7, 8, 13); mix(w, 3, 4, 9, 14);
    end
    for (int i = 0; i < 8; i++)
      keystream_q[i] = {w[2*i+1] + init[2*i+1], w[2*i] + init[2*i]};
    have_block = 1'b1;
  endtask

  task automatic predict_cipher(logic [63:0] txt, logic start);
    cipher_beat_t b;
    if (start) begin
      ctr_q = init_ctr_q;
      pos_q = '0;
      have_block = 1'b0;
    end
    if (!have_block) fill_keystream();
    b.cipher = txt ^ keystream_q[pos_q];
    b.blk = ctr_q;
    expected_beats.push_back(b);
    pos_q++;
    if (pos_q == 0) begin
      ctr_q++;
      have_block = 1'b0;
    end
  endtask

  task automatic write_reg(cc20_pkg::reg_idx_t idx, logic [63:0] val);
    @(negedge clk);
    write_enable <= 1'b1;
    write_index  <= idx;
    write_data   <= val;
    @(negedge clk);
    write_enable <= 1'b0;
    case (idx)
      cc20_pkg::REG_KEY0, cc20_pkg::REG_KEY1,
      cc20_pkg::REG_KEY2, cc20_pkg::REG_KEY3: key_q[idx] = val;
      cc20_pkg::REG_NONCE_LO: nonce_lo_q = val;
      cc20_pkg::REG_NONCE_HI: nonce_hi_q = val[31:0];
      cc20_pkg::REG_INIT_CTR: init_ctr_q = val[31:0];
      default: ;
    endcase
  endtask

  // leaves valid high on return; drain drops it
  task automatic send_word(logic [63:0] txt, logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    text_word     <= txt;
    message_start <= start;
    do @(posedge clk); while (!in_ready);
    predict_cipher(txt, start);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic load_all_regs(logic [63:0] k0, k1, k2, k3, nl, logic [31:0] nh, ic);
    write_reg(cc20_pkg::REG_KEY0, k0);
    write_reg(cc20_pkg::REG_KEY1, k1);
    write_reg(cc20_pkg::REG_KEY2, k2);
    write_reg(cc20_pkg::REG_KEY3, k3);
    write_reg(cc20_pkg::REG_NONCE_LO, nl);
    write_reg(cc20_pkg::REG_NONCE_HI, {32'h0, nh});
    write_reg(cc20_pkg::REG_INIT_CTR, {32'h0, ic});
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_text();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  always @(negedge clk) begin
    if (hold_recv) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cipher_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected beat cipher_word=%h block_number=%h", cipher_word, block_number);
        fail_count++;
      end else begin
        want = expected_beats.pop_front();
        if (cipher_word !== want.cipher) begin
          $error("cipher_word expected %h actual %h", want.cipher, cipher_word);
          fail_count++;
        end
        if (block_number !== want.blk) begin
          $error("block_number expected %h actual %h", want.blk, block_number);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** chacha20_stream_cipher: FAILED **");
      $finish;
    end
  end

  // first block after reset uses counter zero, no message start
  task automatic test_reset_defaults();
    for (int i = 0; i < 10; i++) send_word(i[0] ? '1 : '0, 1'b0);
    drain();
  endtask

  // RFC 8439 section 2.4.2 key/nonce, counter 1
  task automatic test_rfc_vector();
    load_all_regs(64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 64'h1716151413121110,
                  64'h1f1e1d1c1b1a1918, 64'h4a00000000000000, 32'h0, 32'h1);
    for (int i = 0; i < 9; i++) send_word(64'h0, i == 0);
    drain();
  endtask

  // counter wrap and register write mid-block (takes effect on next block)
  task automatic test_counter_wrap();
    load_all_regs('1, '1, '1, '1, '1, '1, 32'hffffffff);
    send_word(64'h0123456789abcdef, 1'b1);
    for (int i = 0; i < 3; i++) send_word(rand64(), 1'b0);
    drain();
    write_reg(cc20_pkg::REG_KEY2, 64'h0);
    for (int i = 0; i < 6; i++) send_word(rand64(), 1'b0);
    send_word(64'h0, 1'b1);
    drain();
  endtask

  task automatic test_random_messages(int n_words, int idle_pct, int stall_pct);
    int left;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    left = n_words;
    while (left > 0) begin
      int len;
      len = $urandom_range(1, 24);
      for (int i = 0; i < len && left > 0; i++) begin
        send_word(rand_text(), i == 0 || $urandom_range(49) == 0);
        left--;
      end
    end
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_recv = 1'b1;
        repeat (200) @(negedge clk);
        hold_recv = 1'b0;
      end
      for (int i = 0; i < 20; i++) send_word(rand64(), i == 0);
    join
    drain();
  endtask

  initial begin
    for (int i = 0; i < 4; i++) key_q[i] = '0;
    nonce_lo_q = '0; nonce_hi_q = '0; init_ctr_q = 32'd1;
    ctr_q = '0; pos_q = '0; have_block = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_rfc_vector();
    test_counter_wrap();
    load_all_regs(rand64(), rand64(), rand64(), rand64(), rand64(), $urandom, $urandom);
    test_random_messages(130, 0, 0);
    load_all_regs(rand64(), rand64(), rand64(), rand64(), rand64(), '0, '0);
    test_random_messages(130, 55, 0);
    load_all_regs(rand64(), rand64(), rand64(), rand64(), rand64(), $urandom, 32'hfffffffe);
    test_random_messages(130, 0, 55);
    load_all_regs(rand64(), rand64(), rand64(), rand64(), rand64(), $urandom, $urandom);
    test_random_messages(130, 7, 7);
    test_backpressure();

    if (fail_count == 0) $display("** chacha20_stream_cipher: PASSED **");
    else $display("** chacha20_stream_cipher: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire
